// ===== rtl/mm64_pkg.sv =====
// Shared constants, types and helpers for the 64-bit string hash engine.
`timescale 1ns / 1ps

package mm64_pkg;

   localparam int WORD_W  = 64;
   localparam int HALF_W  = WORD_W / 2;
   localparam int NB_W    = 4;
   localparam int LEN_W   = 16;
   localparam int SHIFT_R = 47;

   localparam logic [WORD_W-1:0] MUL_M      = 64'hc6a4a7935bd1e995;
   localparam logic [HALF_W-1:0] MUL_M_LO   = MUL_M[HALF_W-1:0];
   localparam logic [HALF_W-1:0] MUL_M_HI   = MUL_M[WORD_W-1:HALF_W];
   localparam logic [WORD_W-1:0] SEED_RESET = 64'd42;

   localparam logic [NB_W-1:0] FULL_BYTES = 4'd8;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

   // Keep the low nb bytes of a word, clear the rest (nb below eight)
   function automatic logic [WORD_W-1:0] byte_mask(input logic [NB_W-1:0] nb);
      logic [WORD_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < WORD_W / 8; i++) begin
         if (NB_W'(i) < nb) begin
            mask[i*8 +: 8] = 8'hff;
         end
      end
      return mask;
   endfunction

   function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] v);
      return v ^ (v >> SHIFT_R);
   endfunction

endpackage

// ===== rtl/mm64_if.sv =====
// Valid/ready channel interfaces for key words and hash results.
`timescale 1ns / 1ps

interface mm64_req_if;
   logic                            valid;
   logic                            ready;
   logic [mm64_pkg::WORD_W-1:0]     data_word;
   logic [mm64_pkg::NB_W-1:0]       valid_bytes;
   logic [mm64_pkg::LEN_W-1:0]      total_length;
   logic                            first_word;
   logic                            last_word;

   modport source (output valid, data_word, valid_bytes, total_length, first_word,
                   last_word, input ready);
   modport sink   (input valid, data_word, valid_bytes, total_length, first_word,
                   last_word, output ready);
endinterface

interface mm64_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mm64_pkg::WORD_W-1:0]     hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

// ===== rtl/murmur_64bit_string_hash.sv =====
// MurmurHash64A engine for byte keys delivered as 64-bit little-endian words.
// A key is sent as a run of transactions, the first flagged by first_word (which also
// carries total_length) and the last by last_word; one hash_value transaction follows
// each last word. The block takes one word at a time and holds req ready low while it
// works. Every 64-bit multiply by the hash constant goes through one shared 32x32
// multiplier in three partial-product steps. A word needs no multiply when it has no
// bytes and is neither first nor last, and five multiplies in a row when it is first,
// full and last. A finished hash waits in the output register while the
// next word is accepted; the block stalls only if a second hash is ready before the
// first has been taken. The seed resets to 42 and is written through csr_wr_en.
`timescale 1ns / 1ps

module murmur_64bit_string_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [mm64_pkg::WORD_W-1:0]     csr_wr_data,
   mm64_req_if.sink                        req_ch,
   mm64_rsp_if.source                      rsp_ch
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LEN  = 3'd1;
   localparam logic [2:0] S_MIX  = 3'd2;
   localparam logic [2:0] S_K1   = 3'd3;
   localparam logic [2:0] S_K2   = 3'd4;
   localparam logic [2:0] S_H    = 3'd5;
   localparam logic [2:0] S_END  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0]                     state_ff, state_in;
   logic [mm64_pkg::WORD_W-1:0]    seed_ff, seed_in;
   logic [mm64_pkg::WORD_W-1:0]    hash_ff, hash_in;
   logic [mm64_pkg::WORD_W-1:0]    word_ff, word_in;
   logic [mm64_pkg::NB_W-1:0]      nb_ff, nb_in;
   logic                           last_ff, last_in;
   logic                           emit_ff, emit_in;
   logic                           out_valid_ff, out_valid_in;
   logic [mm64_pkg::WORD_W-1:0]    out_ff, out_in;

   logic                           mul_start;
   logic [mm64_pkg::WORD_W-1:0]    mul_operand;
   logic [mm64_pkg::WORD_W-1:0]    mul_product;
   mm64_pkg::mul_status_type       mul_status;
   logic                           accept;
   logic                           out_free;

   mm64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (mul_operand),
      .product (mul_product),
      .status  (mul_status)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !emit_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      hash_in      = hash_ff;
      word_in      = word_ff;
      nb_in        = nb_ff;
      last_in      = last_ff;
      emit_in      = emit_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      mul_start    = 1'b0;
      mul_operand  = '0;

      // Hand a finished hash to the output register once it is free
      if (emit_ff && out_free) begin
         out_in       = mm64_pkg::xor_shift(mul_product);
         out_valid_in = 1'b1;
         emit_in      = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               word_in = req_ch.data_word;
               nb_in   = req_ch.valid_bytes;
               last_in = req_ch.last_word;
               if (req_ch.first_word) begin
                  mul_start   = 1'b1;
                  mul_operand = {{(mm64_pkg::WORD_W - mm64_pkg::LEN_W){1'b0}},
                                 req_ch.total_length};
                  state_in    = S_LEN;
               end else begin
                  state_in = S_MIX;
               end
            end
         end
         S_LEN: begin
            if (mul_status.done) begin
               hash_in  = seed_ff ^ mul_product;
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            if (nb_ff >= mm64_pkg::FULL_BYTES) begin
               mul_start   = 1'b1;
               mul_operand = word_ff;
               state_in    = S_K1;
            end else if (nb_ff != '0) begin
               mul_start   = 1'b1;
               mul_operand = hash_ff ^ (word_ff & mm64_pkg::byte_mask(nb_ff));
               state_in    = S_H;
            end else begin
               state_in = S_END;
            end
         end
         S_K1: begin
            if (mul_status.done) begin
               mul_start   = 1'b1;
               mul_operand = mm64_pkg::xor_shift(mul_product);
               state_in    = S_K2;
            end
         end
         S_K2: begin
            if (mul_status.done) begin
               mul_start   = 1'b1;
               mul_operand = hash_ff ^ mul_product;
               state_in    = S_H;
            end
         end
         S_H: begin
            if (mul_status.done) begin
               hash_in  = mul_product;
               state_in = S_END;
            end
         end
         S_END: begin
            // Hold off the finaliser while an earlier hash still waits to be loaded
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!emit_ff) begin
               mul_start   = 1'b1;
               mul_operand = mm64_pkg::xor_shift(hash_ff);
               state_in    = S_FIN;
            end
         end
         S_FIN: begin
            if (mul_status.done) begin
               emit_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= mm64_pkg::SEED_RESET;
         hash_ff      <= '0;
         emit_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         hash_ff      <= hash_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
      end
      word_ff <= word_in;
      nb_ff   <= nb_in;
      last_ff <= last_in;
      out_ff  <= out_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.hash_value = out_ff;

`ifndef SYNTHESIS
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_status.busy)
      else $error("multiplier started while busy");
   a_done_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_status.done |-> state_ff == S_LEN || state_ff == S_K1 || state_ff == S_K2 ||
                          state_ff == S_H || state_ff == S_FIN)
      else $error("multiplier result arrived with nobody waiting");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("second transaction taken while a word is in work");
   a_out_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(emit_ff))
      else $error("result shown without a finished hash");
   a_emit_product_stable: assert property (@(posedge clock) disable iff (reset)
      emit_ff && $past(emit_ff) |-> $stable(mul_product))
      else $error("pending hash overwritten before it was loaded");
`endif

endmodule

// ===== rtl/mm64_mul.sv =====
// Multiply-by-M unit: 64-bit product modulo 2^64 from one 32x32 multiplier.
`timescale 1ns / 1ps

module mm64_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mm64_pkg::WORD_W-1:0]     operand,
   output logic [mm64_pkg::WORD_W-1:0]     product,
   output mm64_pkg::mul_status_type        status
);

   localparam logic [1:0] PH_LO_LO = 2'd0;
   localparam logic [1:0] PH_LO_HI = 2'd1;
   localparam logic [1:0] PH_HI_LO = 2'd2;

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [1:0]                     phase_ff, phase_in;
   logic [mm64_pkg::WORD_W-1:0]    a_ff, a_in;
   logic [mm64_pkg::WORD_W-1:0]    acc_ff, acc_in;
   logic [mm64_pkg::HALF_W-1:0]    mx, my;
   logic [mm64_pkg::WORD_W-1:0]    pp;

   // One partial product per cycle; cross terms only contribute their low half
   always_comb begin
      case (phase_ff)
         PH_LO_LO: begin
            mx = a_ff[mm64_pkg::HALF_W-1:0];
            my = mm64_pkg::MUL_M_LO;
         end
         PH_LO_HI: begin
            mx = a_ff[mm64_pkg::HALF_W-1:0];
            my = mm64_pkg::MUL_M_HI;
         end
         PH_HI_LO: begin
            mx = a_ff[mm64_pkg::WORD_W-1:mm64_pkg::HALF_W];
            my = mm64_pkg::MUL_M_LO;
         end
         default: begin
            mx = '0;
            my = '0;
         end
      endcase
      pp = mx * my;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      a_in     = a_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = PH_LO_LO;
         a_in     = operand;
      end else if (busy_ff) begin
         if (phase_ff == PH_LO_LO) begin
            acc_in = pp;
         end else begin
            acc_in = acc_ff + {pp[mm64_pkg::HALF_W-1:0], {mm64_pkg::HALF_W{1'b0}}};
         end
         if (phase_ff == PH_HI_LO) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_LO_LO;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

`ifndef SYNTHESIS
   a_done_after_last_phase: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && $past(phase_ff) == PH_HI_LO)
      else $error("multiplier done without finishing its last phase");
   a_no_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff || $past(start))
      else $error("multiplier done while still busy");
   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> phase_ff == PH_LO_LO || phase_ff == PH_LO_HI || phase_ff == PH_HI_LO)
      else $error("multiplier phase out of range");
`endif

endmodule
